// File: design/bem_pkg.sv
package bem_pkg;

  localparam int DEFAULT_BLOCK_DEF = 256;
  localparam int COUNT_WIDTH_DEF   = 16;
  localparam int ENTROPY_FRAC_DEF  = 12;

  localparam int NUM_BINS    = 256;
  localparam int BIN_W       = 8;
  localparam int SUM_W       = 24;
  localparam int OFFSET_W    = 32;
  localparam int ACC_W       = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] BLOCK_SIZE_RESET = 16'd256;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [31:0] block_offset;
    logic [15:0] block_length;
    logic [15:0] entropy_bits;
    logic [15:0] mean_byte;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_LOGN,
    ST_RD,
    ST_CHK,
    ST_LOGC,
    ST_MUL,
    ST_ACC,
    ST_DIVS,
    ST_DIVE,
    ST_MEANS,
    ST_DIVM,
    ST_OUT
  } back_state_e;

endpackage

// File: design/bem_front.sv
module bem_front import bem_pkg::*; #(
  parameter int DEFAULT_BLOCK = DEFAULT_BLOCK_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
  localparam int JOB_W        = BIN_W + 1 + COUNT_WIDTH + SUM_W + OFFSET_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             accept_i,
  input  in_word_t         in_word_i,
  output logic [JOB_W-1:0] job_o
);

  typedef struct packed {
    logic [BIN_W-1:0]       byte_val;
    logic                   close;
    logic [COUNT_WIDTH-1:0] n;
    logic [SUM_W-1:0]       sum;
    logic [OFFSET_W-1:0]    offset;
  } job_t;

  localparam logic [COUNT_WIDTH-1:0] CAP = '1;

  logic [15:0]            blk_size_q;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [OFFSET_W-1:0]    offset_q, offset_d;
  logic [31:0]            eff;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [SUM_W-1:0]       sum_new;
  job_t                   job;

  always_comb begin
    eff = (blk_size_q == 16'd0) ? 32'(DEFAULT_BLOCK) : 32'(blk_size_q);
    if (eff > 32'(CAP)) begin
      eff = 32'(CAP);
    end
    cnt_new = count_q + COUNT_WIDTH'(1);
    sum_new = sum_q + SUM_W'(in_word_i.byte_value);
    job.byte_val = in_word_i.byte_value;
    job.close    = in_word_i.end_of_data || (32'(cnt_new) >= eff);
    job.n        = cnt_new;
    job.sum      = sum_new;
    job.offset   = offset_q;
  end

  assign job_o = job;

  always_comb begin
    count_d  = count_q;
    sum_d    = sum_q;
    offset_d = offset_q;
    if (accept_i) begin
      if (job.close) begin
        count_d  = '0;
        sum_d    = '0;
        offset_d = in_word_i.end_of_data ? '0 : offset_q + OFFSET_W'(cnt_new);
      end else begin
        count_d = cnt_new;
        sum_d   = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_size_q <= BLOCK_SIZE_RESET;
      count_q    <= '0;
      sum_q      <= '0;
      offset_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        blk_size_q <= cfg_wdata_i;
      end
      count_q  <= count_d;
      sum_q    <= sum_d;
      offset_q <= offset_d;
    end
  end

endmodule

// File: design/bem_fifo.sv
module bem_fifo import bem_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

// File: design/bem_log2.sv
module bem_log2 import bem_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int IPW        = $clog2(COUNT_WIDTH),
  localparam int LOG_W      = 32 + IPW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COUNT_WIDTH-1:0] x_i,
  output logic [LOG_W-1:0]       log_o,
  output logic                   done_o
);

  logic           busy_q, done_q;
  logic [5:0]     cnt_q;
  logic [31:0]    y_q, frac_q;
  logic [IPW-1:0] ip_q;
  logic [IPW-1:0] ip;
  logic [31:0]    y_init;
  logic [63:0]    sq;
  logic [32:0]    t;

  // leading one position of the argument
  always_comb begin
    ip = '0;
    for (int i = 0; i < COUNT_WIDTH; i++) begin
      if (x_i[i]) begin
        ip = IPW'(i);
      end
    end
    y_init = 32'(x_i) << (6'd31 - 6'(ip));
    sq     = 64'(y_q) * 64'(y_q);
    t      = sq[63:31];
  end

  assign log_o  = {ip_q, frac_q};
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (x_i <= COUNT_WIDTH'(1)) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 6'd32;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one fraction bit per squaring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i <= COUNT_WIDTH'(1)) begin
        ip_q   <= '0;
        frac_q <= '0;
      end else begin
        ip_q   <= ip;
        frac_q <= '0;
        y_q    <= y_init;
      end
    end else if (busy_q) begin
      y_q    <= t[32] ? t[32:1] : t[31:0];
      frac_q <= {frac_q[30:0], t[32]};
    end
  end

endmodule

// File: design/bem_div.sv
module bem_div import bem_pkg::*; #(
  parameter int DEN_W = COUNT_WIDTH_DEF,
  localparam int CW   = $clog2(ACC_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [ACC_W-1:0] quo_o,
  output logic             done_o
);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [ACC_W-1:0] quo_q;
  logic [DEN_W:0]   t;
  logic             ge;

  always_comb begin
    t  = {rem_q, quo_q[ACC_W-1]};
    ge = (t >= {1'b0, den_q});
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ACC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(t - {1'b0, den_q}) : t[DEN_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

endmodule

// File: design/bem_back.sv
module bem_back import bem_pkg::*; #(
  parameter int COUNT_WIDTH       = COUNT_WIDTH_DEF,
  parameter int ENTROPY_FRAC_BITS = ENTROPY_FRAC_DEF,
  localparam int JOB_W            = BIN_W + 1 + COUNT_WIDTH + SUM_W + OFFSET_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [JOB_W-1:0] job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output logic             clearing_o,
  output logic             out_valid_o,
  output out_word_t        out_word_o,
  input  logic             out_pop_i
);

  typedef struct packed {
    logic [BIN_W-1:0]       byte_val;
    logic                   close;
    logic [COUNT_WIDTH-1:0] n;
    logic [SUM_W-1:0]       sum;
    logic [OFFSET_W-1:0]    offset;
  } job_t;

  localparam int LOG_W  = 32 + $clog2(COUNT_WIDTH);
  localparam int PROD_W = COUNT_WIDTH + LOG_W;
  localparam int RND_SH = 31 - ENTROPY_FRAC_BITS;
  localparam int OUT_SH = 32 - ENTROPY_FRAC_BITS;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  back_state_e state_q, state_d;

  job_t                   job_in, job_q;
  logic [COUNT_WIDTH-1:0] hist_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] mem_rdata_q;
  logic                   mem_we;
  logic [BIN_W-1:0]       mem_waddr, mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  logic [BIN_W-1:0]       bin_q;
  logic [LOG_W-1:0]       ln_q, lg_q;
  logic [COUNT_WIDTH-1:0] c_q;
  logic [PROD_W-1:0]      prod_q;
  logic [ACC_W-1:0]       s_q;
  logic [15:0]            ent_q, mean_q;
  logic                   out_valid_q;
  out_word_t              out_q;

  logic                   log_start, log_done;
  logic [COUNT_WIDTH-1:0] log_x;
  logic [LOG_W-1:0]       log_res;
  logic                   div_start, div_done;
  logic [ACC_W-1:0]       div_num, div_quo;
  logic                   last_bin;
  logic [ACC_W-1:0]       h, r;
  logic [31:0]            len32;

  assign job_in   = job_t'(job_i);
  assign last_bin = (bin_q == LAST_BIN);

  bem_log2 #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_log2 (
    .clk_i,
    .rst_ni,
    .start_i(log_start),
    .x_i    (log_x),
    .log_o  (log_res),
    .done_o (log_done)
  );

  bem_div #(
    .DEN_W(COUNT_WIDTH)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (job_q.n),
    .quo_o  (div_quo),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= hist_mem[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (last_bin) state_d = ST_IDLE;
      ST_IDLE:  if (!job_empty_i) state_d = ST_INC;
      ST_INC:   state_d = job_q.close ? ST_LOGN : ST_IDLE;
      ST_LOGN:  if (log_done) state_d = ST_RD;
      ST_RD:    state_d = ST_CHK;
      ST_CHK: begin
        if (mem_rdata_q > COUNT_WIDTH'(1)) state_d = ST_LOGC;
        else state_d = last_bin ? ST_DIVS : ST_RD;
      end
      ST_LOGC:  if (log_done) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = last_bin ? ST_DIVS : ST_RD;
      ST_DIVS:  state_d = ST_DIVE;
      ST_DIVE:  if (div_done) state_d = ST_MEANS;
      ST_MEANS: state_d = ST_DIVM;
      ST_DIVM:  if (div_done) state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bin_q;
    mem_wdata = '0;
    mem_raddr = bin_q;
    job_pop_o = 1'b0;
    log_start = 1'b0;
    log_x     = mem_rdata_q;
    div_start = 1'b0;
    div_num   = s_q;
    case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        mem_raddr = job_in.byte_val;
        job_pop_o = !job_empty_i;
      end
      ST_INC: begin
        mem_we    = 1'b1;
        mem_waddr = job_q.byte_val;
        mem_wdata = mem_rdata_q + COUNT_WIDTH'(1);
        log_start = job_q.close;
        log_x     = job_q.n;
      end
      ST_CHK: begin
        // bin is read out and cleared for the next block
        mem_we    = 1'b1;
        log_start = (mem_rdata_q > COUNT_WIDTH'(1));
      end
      ST_DIVS: div_start = 1'b1;
      ST_MEANS: begin
        div_start = 1'b1;
        div_num   = (ACC_W'(job_q.sum) << 8) + ACC_W'(job_q.n >> 1);
      end
      default: ;
    endcase
  end

  always_comb begin
    h = (div_quo > ACC_W'(ln_q)) ? '0 : ACC_W'(ln_q) - div_quo;
    r = (h + (ACC_W'(1) << RND_SH)) >> OUT_SH;
    len32 = 32'(job_q.n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      bin_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_CLEAR: bin_q <= bin_q + BIN_W'(1);
        ST_LOGN:  if (log_done) bin_q <= '0;
        ST_CHK: begin
          if (mem_rdata_q <= COUNT_WIDTH'(1) && !last_bin) bin_q <= bin_q + BIN_W'(1);
        end
        ST_ACC:   if (!last_bin) bin_q <= bin_q + BIN_W'(1);
        default: ;
      endcase
      if (state_q == ST_OUT && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (!job_empty_i) job_q <= job_in;
      ST_LOGN: begin
        if (log_done) begin
          ln_q <= log_res;
          s_q  <= '0;
        end
      end
      ST_CHK:  c_q <= mem_rdata_q;
      ST_LOGC: if (log_done) lg_q <= log_res;
      ST_MUL:  prod_q <= PROD_W'(c_q) * PROD_W'(lg_q);
      ST_ACC:  s_q <= s_q + ACC_W'(prod_q);
      ST_DIVE: begin
        if (div_done) ent_q <= (r > ACC_W'(16'hFFFF)) ? 16'hFFFF : r[15:0];
      end
      ST_DIVM: if (div_done) mean_q <= div_quo[15:0];
      ST_OUT: begin
        if (!out_valid_q) begin
          out_q.block_offset <= job_q.offset;
          out_q.block_length <= len32[15:0];
          out_q.entropy_bits <= ent_q;
          out_q.mean_byte    <= mean_q;
        end
      end
      default: ;
    endcase
  end

  assign clearing_o  = (state_q == ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: design/block_entropy_and_mean.sv
// channel   direction  handshake          word
// input     in         push_i / full_o    in_word_i   (byte_value, end_of_data)
// result    out        pop_i / empty_o    out_word_o  (offset, length, entropy, mean)
// config    in         cfg_we_i           cfg_wdata_i (bytes per block)
//
// the front takes a byte every cycle while its four-word queue has room and no
// clear sweep runs; the back reads, then increments, the histogram bin per byte
// closing a block takes log2 of the length, then reads and clears every bin, taking
// log2 of each bin holding more than one byte, and ends with two divides
// after reset a sweep clears all 256 histogram bins, full_o high throughout
// a result waiting on pop_i can hold the back; the front runs until its queue fills
module block_entropy_and_mean import bem_pkg::*; #(
  parameter int DEFAULT_BLOCK     = DEFAULT_BLOCK_DEF,
  parameter int COUNT_WIDTH       = COUNT_WIDTH_DEF,
  parameter int ENTROPY_FRAC_BITS = ENTROPY_FRAC_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push_i,
  output logic        full_o,
  input  in_word_t    in_word_i,
  output logic        empty_o,
  input  logic        pop_i,
  output out_word_t   out_word_o
);

  localparam int JOB_W = BIN_W + 1 + COUNT_WIDTH + SUM_W + OFFSET_W;

  logic             accept;
  logic [JOB_W-1:0] job_w, job_head;
  logic             q_full, q_empty, q_pop;
  logic             clearing;
  logic             out_valid;

  assign full_o  = q_full || clearing;
  assign accept  = push_i && !full_o;
  assign empty_o = !out_valid;

  bem_front #(
    .DEFAULT_BLOCK(DEFAULT_BLOCK),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .accept_i (accept),
    .in_word_i,
    .job_o    (job_w)
  );

  bem_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (accept),
    .wdata_i(job_w),
    .pop_i  (q_pop),
    .rdata_o(job_head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  bem_back #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .ENTROPY_FRAC_BITS(ENTROPY_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .job_i      (job_head),
    .job_empty_i(q_empty),
    .job_pop_o  (q_pop),
    .clearing_o (clearing),
    .out_valid_o(out_valid),
    .out_word_o,
    .out_pop_i  (pop_i)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !q_full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && !clearing)
    else $error("job queue underflow");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> out_word_o.mean_byte <= 16'hFF00)
    else $error("mean out of range");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bem_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        push_i;
  logic        full_o;
  in_word_t    in_word_i;
  logic        empty_o;
  logic        pop_i;
  out_word_t   out_word_o;

  block_entropy_and_mean dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_word_i   (in_word_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_word_o  (out_word_o)
  );

  in_word_t  byte_queue[$];
  out_word_t block_results[$];

  // model of the block state
  logic [15:0] size_reg;
  logic [15:0] bin_count [NUM_BINS];
  logic [15:0] run_count;
  logic [23:0] run_sum;
  logic [31:0] run_offset;

  int errors;
  bit quiet;
  bit hold_input;
  bit word_taken;
  int push_gap;
  int pop_gap;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("block_entropy_and_mean regression: fail");
    $finish;
  end

  // log2 with 32 fraction bits
  function automatic longint unsigned log2_fix(int unsigned x);
    int unsigned ip;
    longint unsigned y;
    longint unsigned frac;
    ip = 0;
    frac = 0;
    if (x <= 1) return 0;
    while ((x >> ip) > 1) ip++;
    y = longint'(x) << (31 - ip);
    for (int i = 0; i < 32; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(ip) << 32) | frac;
  endfunction

  function automatic out_word_t close_block(bit eod);
    out_word_t w;
    longint unsigned s, q, h, r, ln, n;
    s = 0;
    n = (run_count == 0) ? 1 : run_count;
    ln = log2_fix(n);
    for (int i = 0; i < NUM_BINS; i++)
      if (bin_count[i] > 1) s += longint'(bin_count[i]) * log2_fix(bin_count[i]);
    q = s / n;
    h = (q > ln) ? 0 : ln - q;
    r = (h + (64'd1 << (31 - ENTROPY_FRAC_DEF))) >> (32 - ENTROPY_FRAC_DEF);
    if (r > 16'hFFFF) r = 16'hFFFF;
    w.block_offset = run_offset;
    w.block_length = n[15:0];
    w.entropy_bits = r[15:0];
    w.mean_byte    = 16'(((longint'(run_sum) << 8) + (n >> 1)) / n);
    run_offset = eod ? 32'd0 : run_offset + 32'(n);
    foreach (bin_count[i]) bin_count[i] = '0;
    run_count = '0;
    run_sum = '0;
    return w;
  endfunction

  // monitor: config, accepted words and results
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    int unsigned eff;
    int d;
    if (!rst_ni) begin
      size_reg = BLOCK_SIZE_RESET;
      foreach (bin_count[i]) bin_count[i] = '0;
      run_count = '0;
      run_sum = '0;
      run_offset = '0;
      word_taken <= 1'b0;
    end else begin
      if (cfg_we_i) size_reg = cfg_wdata_i;
      word_taken <= push_i && !full_o;
      if (push_i && !full_o) begin
        eff = (size_reg == 0) ? DEFAULT_BLOCK_DEF : size_reg;
        bin_count[in_word_i.byte_value] = bin_count[in_word_i.byte_value] + 1;
        run_count = run_count + 1;
        run_sum = run_sum + in_word_i.byte_value;
        if (in_word_i.end_of_data || run_count >= eff)
          block_results.push_back(close_block(in_word_i.end_of_data));
      end
      if (pop_i && !empty_o) begin
        if (block_results.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word_o);
          errors++;
        end else begin
          exp_w = block_results.pop_front();
          d = int'(exp_w.entropy_bits) - int'(out_word_o.entropy_bits);
          if (exp_w.block_offset != out_word_o.block_offset ||
              exp_w.block_length != out_word_o.block_length ||
              exp_w.mean_byte != out_word_o.mean_byte || d > 1 || d < -1) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_w, out_word_o);
            errors++;
          end
        end
      end
    end
  end

  // driver for the input side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (word_taken) void'(byte_queue.pop_front());
      if (push_gap > 0) begin
        push_gap--;
        push_i <= 1'b0;
      end else if (byte_queue.size() > 0 && !hold_input) begin
        push_i <= 1'b1;
        in_word_i <= byte_queue[0];
        if (!quiet && $urandom_range(0, 7) == 0) push_gap = $urandom_range(1, 3);
      end else begin
        push_i <= 1'b0;
      end
    end
  end

  // result side stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop_gap > 0) begin
        pop_gap--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) pop_gap = $urandom_range(1, 3);
      end
    end
  end

  task automatic send(logic [7:0] b, logic eod);
    in_word_t w;
    w.byte_value = b;
    w.end_of_data = eod;
    byte_queue.push_back(w);
  endtask

  // wait until the block has nothing left in flight
  task automatic drain();
    wait (byte_queue.size() == 0 && block_results.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_size(logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int n_items;
    int mode;
    logic [7:0] fixed_b;
    logic [7:0] b;
    errors = 0;
    quiet = 0;
    hold_input = 0;
    push_gap = 0;
    pop_gap = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    push_i = 1'b0;
    pop_i = 1'b0;
    in_word_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: blocks closed by count and by end mark
    write_size(16'd4);
    send(8'h00, 0); send(8'hFF, 0); send(8'hAA, 0); send(8'h55, 0);
    send(8'h07, 0); send(8'h07, 0); send(8'h07, 1);
    send(8'h80, 1);
    drain();
    write_size(16'd1);
    send(8'h01, 0); send(8'hFE, 0); send(8'h33, 1);
    drain();
    // shrink mid-block: the next word closes it
    write_size(16'd8);
    send(8'h10, 0); send(8'h10, 0); send(8'h20, 0); send(8'h40, 0); send(8'h10, 0);
    drain();
    write_size(16'd3);
    send(8'hC3, 0); send(8'h3C, 1);
    drain();
    // largest size, closed by end mark
    write_size(16'hFFFF);
    send(8'hFF, 0); send(8'hFF, 0); send(8'h00, 1);
    drain();
    write_size(16'd0);
    send(8'h11, 0); send(8'h22, 1);
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 11) quiet = 1;
      case ($urandom_range(0, 5))
        0: write_size(16'd0);
        1: write_size(16'hFFFF);
        2: write_size(16'd1);
        default: write_size(16'($urandom_range(2, 40)));
      endcase
      mode = $urandom_range(0, 2);
      fixed_b = 8'($urandom);
      n_items = $urandom_range(25, 50);
      for (int i = 0; i < n_items; i++) begin
        case (mode)
          0: b = 8'($urandom);
          1: b = 8'($urandom_range(0, 3)) ^ fixed_b;
          default: b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : fixed_b;
        endcase
        send(b, ($urandom_range(0, 29) == 0) || (i == n_items - 1 && ph % 3 == 0));
        if (ph == 5 && i == 20) begin
          // sender waits for every outstanding result
          wait (byte_queue.size() == 0);
          hold_input = 1;
          wait (block_results.size() == 0);
          hold_input = 0;
        end
      end
      drain();
    end

    wait (byte_queue.size() == 0 && block_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("block_entropy_and_mean regression: pass");
    end else begin
      $display("block_entropy_and_mean regression: fail");
    end
    $finish;
  end

endmodule
